[rtl/scc_style_rom_bank_mapper_unit_macros.svh]
// ---------------------------------------------------------------------------
// scc style rom bank mapper - assertion macros
// shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is low
// ---------------------------------------------------------------------------
`ifndef SCC_STYLE_ROM_BANK_MAPPER_UNIT_MACROS_SVH
`define SCC_STYLE_ROM_BANK_MAPPER_UNIT_MACROS_SVH

// plain property
`define SRBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define SRBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `SRBM_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define SRBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `SRBM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/srbm_pkg.sv]
// ---------------------------------------------------------------------------
// srbm_pkg
// types, constants and helper functions of the rom bank mapper
// ---------------------------------------------------------------------------
package srbm_pkg;

    localparam int BANK_PAGES = 4;
    localparam int PAGE_W     = $clog2(BANK_PAGES);
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int BANK_W     = 10;
    localparam int OFS_W      = 13;
    localparam int FLASH_W    = BANK_W + OFS_W;
    localparam int ID_W       = 3;

    localparam logic [ADDR_W-1:0] WINDOW_BASE    = 16'h4000;
    localparam logic [ADDR_W-1:0] MIRROR_FLIP    = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_ENABLE     = 16'h7fff;
    localparam logic [ADDR_W-1:0] REG_OFFSET     = 16'h7ffe;
    localparam logic [ADDR_W-1:0] REG_CONFIG     = 16'h7ffd;
    localparam logic [ADDR_W-1:0] REG_ID         = 16'h7ffc;
    localparam logic [ADDR_W-1:0] SND_PLUS_LO    = 16'hb800;
    localparam logic [ADDR_W-1:0] SND_PLUS_HI    = 16'hbffe;
    localparam logic [ADDR_W-1:0] SND_REAL_LO    = 16'h9800;
    localparam logic [ADDR_W-1:0] SND_REAL_HI    = 16'ha000;
    localparam logic [ADDR_W-1:0] MODE_ADDR      = 16'hbffe;
    localparam logic [ADDR_W-1:0] MODE_ADDR_MASK = 16'hfffe;
    localparam logic [ADDR_W-1:0] BANK_SEL_MASK  = 16'h1800;
    localparam logic [ADDR_W-1:0] BANK_SEL_MATCH = 16'h1000;
    localparam logic [ADDR_W-1:0] BANK_MIN_ADDR  = 16'h6000;
    localparam logic [ADDR_W-1:0] FIRST_PAGE     = 16'd2;

    localparam logic [DATA_W-1:0] BYTE_NONE      = 8'hff;
    localparam logic [5:0]        SND_REAL_KEY   = 6'h3f;
    localparam logic [ID_W-1:0]   ID_LAST        = 3'd4;
    localparam logic [BANK_W-1:0] BANK_MASK_RST  = 10'h3;

    localparam logic [PAGE_W-1:0] SND_PLUS_PAGE  = PAGE_W'(3 % BANK_PAGES);
    localparam logic [PAGE_W-1:0] SND_REAL_PAGE  = PAGE_W'(2 % BANK_PAGES);

    // register bit positions
    localparam int EN_REGS     = 0;
    localparam int EN_FLASH_WR = 4;
    localparam int CFG_LOCK    = 0;
    localparam int CFG_ROM_OFF = 2;
    localparam int CFG_SND_OFF = 3;
    localparam int CFG_ID_EN   = 6;
    localparam int CFG_BUSY    = 7;
    localparam int SND_PLUS    = 5;
    localparam int RAW_SND_ON  = 7;

    typedef enum logic [1:0] {
        SRC_DATA  = 2'd0,
        SRC_SOUND = 2'd1,
        SRC_FLASH = 2'd2,
        SRC_WRITE = 2'd3
    } t_src;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_access;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        t_src               data_source;
        logic [FLASH_W-1:0] flash_address;
        logic [DATA_W-1:0]  sound_address;
        logic               sound_write;
        logic               sound_plus_mode;
    } t_result;

    function automatic logic [DATA_W-1:0] id_byte(input logic [ID_W-1:0] step);
        logic [DATA_W-1:0] b;
        case (step)
            3'd0:    b = 8'hff;
            3'd1:    b = 8'h1f;
            3'd2:    b = 8'h23;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            default: b = BYTE_NONE;
        endcase
        return b;
    endfunction

endpackage

[rtl/srbm_if.sv]
// ---------------------------------------------------------------------------
// srbm_if
// valid/ready channels for bus accesses and mapper results
// ---------------------------------------------------------------------------
interface srbm_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [srbm_pkg::ADDR_W-1:0] address;
    logic [srbm_pkg::DATA_W-1:0] write_data;

    modport source (output valid, req_type, address, write_data, input ready);
    modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

interface srbm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [srbm_pkg::DATA_W-1:0]  read_data;
    logic [1:0]                  data_source;
    logic [srbm_pkg::FLASH_W-1:0] flash_address;
    logic [srbm_pkg::DATA_W-1:0]  sound_address;
    logic                        sound_write;
    logic                        sound_plus_mode;

    modport source (output valid, read_data, data_source, flash_address, sound_address,
                    sound_write, sound_plus_mode, input ready);
    modport sink   (input valid, read_data, data_source, flash_address, sound_address,
                    sound_write, sound_plus_mode, output ready);
endinterface

[rtl/srbm_in_stage.sv]
// ---------------------------------------------------------------------------
// srbm_in_stage
// input register for bus accesses, refilled in the cycle it drains
// ---------------------------------------------------------------------------
module srbm_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srbm_req_if.sink          i_req,
    input  logic              i_take,
    output logic              o_valid,
    output srbm_pkg::t_access o_access
);

    logic              r_valid;
    logic              n_valid;
    srbm_pkg::t_access r_access;
    logic              accept;

    assign i_req.ready = !r_valid || i_take;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_access.req_type   <= i_req.req_type;
            r_access.address    <= i_req.address;
            r_access.write_data <= i_req.write_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_access = r_access;

endmodule

[rtl/srbm_core.sv]
// ---------------------------------------------------------------------------
// srbm_core
// mapper registers, bank tables and the single-pass access decode
// ---------------------------------------------------------------------------
module srbm_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srbm_pkg::BANK_W-1:0]   i_cfg_wdata,
    input  logic                          i_fire,
    input  srbm_pkg::t_access             i_access,
    output srbm_pkg::t_result             o_result
);

    localparam int NP = srbm_pkg::BANK_PAGES;
    localparam int PW = srbm_pkg::PAGE_W;
    localparam int AW = srbm_pkg::ADDR_W;
    localparam int DW = srbm_pkg::DATA_W;
    localparam int BW = srbm_pkg::BANK_W;

    logic [BW-1:0]              r_bank_mask;
    logic [DW-1:0]              r_enable,     n_enable;
    logic [DW-1:0]              r_offset,     n_offset;
    logic [DW-1:0]              r_config,     n_config;
    logic [DW-1:0]              r_sound_mode, n_sound_mode;
    logic [srbm_pkg::ID_W-1:0]  r_id_step,    n_id_step;
    logic [DW-1:0]              r_raw_bank [NP];
    logic [DW-1:0]              n_raw_bank [NP];
    logic [BW-1:0]              r_eff_bank [NP];
    logic [BW-1:0]              n_eff_bank [NP];

    logic [AW-1:0] addr;
    logic [AW-1:0] mirr;
    logic [PW-1:0] page;
    logic          in_regs;
    logic          sound_hit;
    logic          bank_we;
    logic [BW-1:0] bank_off;
    logic [BW-1:0] flash_bank;

    always_comb begin
        addr    = i_access.address + srbm_pkg::WINDOW_BASE;
        in_regs = (addr[AW-1:2] == srbm_pkg::REG_ID[AW-1:2]);
        // fold everything outside the cartridge window back into it
        mirr = (addr[15:14] == 2'b00 || addr[15:14] == 2'b11)
             ? (addr ^ srbm_pkg::MIRROR_FLIP) : addr;
        page = PW'((mirr >> srbm_pkg::OFS_W) - srbm_pkg::FIRST_PAGE);

        sound_hit = 1'b0;
        if (!r_config[srbm_pkg::CFG_SND_OFF]) begin
            if (r_sound_mode[srbm_pkg::SND_PLUS]) begin
                sound_hit = r_raw_bank[srbm_pkg::SND_PLUS_PAGE][srbm_pkg::RAW_SND_ON]
                         && mirr >= srbm_pkg::SND_PLUS_LO && mirr < srbm_pkg::SND_PLUS_HI;
            end else begin
                sound_hit = (r_raw_bank[srbm_pkg::SND_REAL_PAGE][5:0] == srbm_pkg::SND_REAL_KEY)
                         && mirr >= srbm_pkg::SND_REAL_LO && mirr < srbm_pkg::SND_REAL_HI;
            end
        end

        flash_bank = r_eff_bank[page] & r_bank_mask;
        bank_off   = {r_offset, r_config[5:4]};
    end

    always_comb begin
        n_enable     = r_enable;
        n_offset     = r_offset;
        n_config     = r_config;
        n_sound_mode = r_sound_mode;
        n_id_step    = r_id_step;
        n_raw_bank   = r_raw_bank;
        n_eff_bank   = r_eff_bank;
        bank_we      = 1'b0;

        o_result.read_data     = srbm_pkg::BYTE_NONE;
        o_result.data_source   = srbm_pkg::SRC_DATA;
        o_result.flash_address = '0;
        o_result.sound_address = '0;
        o_result.sound_write   = 1'b0;

        if (!i_access.req_type) begin
            if (in_regs && r_enable[srbm_pkg::EN_REGS]) begin
                case (addr)
                    srbm_pkg::REG_ID: begin
                        o_result.read_data = r_config[srbm_pkg::CFG_ID_EN]
                                           ? srbm_pkg::id_byte(r_id_step)
                                           : srbm_pkg::BYTE_NONE;
                    end
                    srbm_pkg::REG_CONFIG: begin
                        o_result.read_data = r_config | DW'(1 << srbm_pkg::CFG_BUSY);
                    end
                    srbm_pkg::REG_OFFSET: begin
                        o_result.read_data = r_offset;
                    end
                    default: begin
                        o_result.read_data = r_enable;
                    end
                endcase
            end else if (sound_hit) begin
                o_result.data_source   = srbm_pkg::SRC_SOUND;
                o_result.sound_address = mirr[DW-1:0];
            end else if (!r_config[srbm_pkg::CFG_ROM_OFF]) begin
                o_result.data_source   = srbm_pkg::SRC_FLASH;
                o_result.flash_address = {flash_bank, mirr[srbm_pkg::OFS_W-1:0]};
            end
        end else begin
            o_result.data_source = srbm_pkg::SRC_WRITE;
            if (in_regs) begin
                if (addr == srbm_pkg::REG_ENABLE) begin
                    n_enable = i_access.write_data;
                end else if (r_enable[srbm_pkg::EN_REGS]) begin
                    case (addr)
                        srbm_pkg::REG_ID: begin
                            if (r_config[srbm_pkg::CFG_ID_EN]) begin
                                n_id_step = (r_id_step < srbm_pkg::ID_LAST)
                                          ? r_id_step + 1'b1 : '0;
                            end
                        end
                        srbm_pkg::REG_CONFIG: begin
                            n_config = i_access.write_data;
                        end
                        default: begin
                            n_offset = i_access.write_data;
                        end
                    endcase
                end
            end else if (!r_enable[srbm_pkg::EN_FLASH_WR]) begin
                if (r_config[srbm_pkg::CFG_SND_OFF]) begin
                    bank_we = !r_config[srbm_pkg::CFG_LOCK] && mirr >= srbm_pkg::BANK_MIN_ADDR;
                end else begin
                    if (sound_hit) begin
                        o_result.sound_write   = 1'b1;
                        o_result.sound_address = mirr[DW-1:0];
                    end
                    bank_we = ((mirr & srbm_pkg::BANK_SEL_MASK) == srbm_pkg::BANK_SEL_MATCH)
                           && !r_config[srbm_pkg::CFG_LOCK];
                    if ((mirr & srbm_pkg::MODE_ADDR_MASK) == srbm_pkg::MODE_ADDR) begin
                        n_sound_mode = i_access.write_data;
                    end
                end
            end
        end

        for (int i = 0; i < NP; i++) begin
            if (bank_we && page == PW'(i)) begin
                n_raw_bank[i] = i_access.write_data;
                n_eff_bank[i] = BW'(i_access.write_data) + bank_off;
            end
        end

        o_result.sound_plus_mode = n_sound_mode[srbm_pkg::SND_PLUS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_mask <= srbm_pkg::BANK_MASK_RST;
        end else if (i_cfg_we) begin
            r_bank_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= '0;
            r_offset     <= '0;
            r_config     <= '0;
            r_sound_mode <= '0;
            r_id_step    <= '0;
            for (int i = 0; i < NP; i++) begin
                r_raw_bank[i] <= DW'(i);
                r_eff_bank[i] <= BW'(i);
            end
        end else if (i_fire) begin
            r_enable     <= n_enable;
            r_offset     <= n_offset;
            r_config     <= n_config;
            r_sound_mode <= n_sound_mode;
            r_id_step    <= n_id_step;
            r_raw_bank   <= n_raw_bank;
            r_eff_bank   <= n_eff_bank;
        end
    end

endmodule

[rtl/srbm_out_stage.sv]
// ---------------------------------------------------------------------------
// srbm_out_stage
// result register, takes a new result while the current one is collected
// ---------------------------------------------------------------------------
module srbm_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  srbm_pkg::t_result i_result,
    output logic              o_ready,
    srbm_rsp_if.source        o_rsp
);

    logic              r_valid;
    logic              n_valid;
    srbm_pkg::t_result r_result;
    logic              load;

    assign o_ready = !r_valid || o_rsp.ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.read_data       = r_result.read_data;
    assign o_rsp.data_source     = r_result.data_source;
    assign o_rsp.flash_address   = r_result.flash_address;
    assign o_rsp.sound_address   = r_result.sound_address;
    assign o_rsp.sound_write     = r_result.sound_write;
    assign o_rsp.sound_plus_mode = r_result.sound_plus_mode;

endmodule

[rtl/scc_style_rom_bank_mapper_unit.sv]
// ---------------------------------------------------------------------------
// scc_style_rom_bank_mapper_unit
// cartridge bank mapper with sound-chip window and extended register block
// ---------------------------------------------------------------------------
// One bus access per clock is accepted and each gives exactly one result,
// held first in the input register and then in the result register. The
// decode, bank table lookup and register update sit in one combinational
// pass between those registers, so back-to-back accesses run at one item
// per cycle; the only stall comes from the result side holding ready low.
// The bank mask is written through i_cfg_we/i_cfg_wdata and takes effect
// for the next access decoded; it resets to 3.
module scc_style_rom_bank_mapper_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srbm_pkg::BANK_W-1:0] i_cfg_wdata,
    srbm_req_if.sink                    i_req,
    srbm_rsp_if.source                  o_rsp
);

    logic              in_valid;
    srbm_pkg::t_access in_access;
    logic              out_ready;
    logic              fire;
    srbm_pkg::t_result result;

    // an access is decoded once the result register has room for it
    assign fire = in_valid && out_ready;

    srbm_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_take   (fire),
        .o_valid  (in_valid),
        .o_access (in_access)
    );

    srbm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_access    (in_access),
        .o_result    (result)
    );

    srbm_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_result (result),
        .o_ready  (out_ready),
        .o_rsp    (o_rsp)
    );

endmodule

[rtl/srbm_checker.sv]
// ---------------------------------------------------------------------------
// srbm_checker
// port-level checks on the mapper results, bound to the top level
// ---------------------------------------------------------------------------
`include "scc_style_rom_bank_mapper_unit_macros.svh"

module srbm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [srbm_pkg::DATA_W-1:0]  i_rsp_read_data,
    input logic [1:0]                   i_rsp_data_source,
    input logic [srbm_pkg::FLASH_W-1:0] i_rsp_flash_address,
    input logic [srbm_pkg::DATA_W-1:0]  i_rsp_sound_address,
    input logic                         i_rsp_sound_write
);

    `SRBM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_read_data), "result dropped or changed while stalled")

    // flash address only meaningful on a flash read
    `SRBM_ASSERT_IMP(a_flash_addr_idle, i_clk, i_rst_n, i_rsp_valid && (i_rsp_data_source != srbm_pkg::SRC_FLASH), i_rsp_flash_address == '0, "flash address set on non-flash result")

    `SRBM_ASSERT_IMP(a_write_byte, i_clk, i_rst_n, i_rsp_valid && (i_rsp_data_source == srbm_pkg::SRC_WRITE), i_rsp_read_data == srbm_pkg::BYTE_NONE, "write result carries read data")

    `SRBM_ASSERT_IMP(a_sound_wr_src, i_clk, i_rst_n, i_rsp_valid && i_rsp_sound_write, i_rsp_data_source == srbm_pkg::SRC_WRITE, "sound write flagged on a read")

    `SRBM_ASSERT_IMP(a_sound_addr_idle, i_clk, i_rst_n, i_rsp_valid && (i_rsp_data_source != srbm_pkg::SRC_SOUND) && !i_rsp_sound_write, i_rsp_sound_address == '0, "sound address set without sound access")

endmodule

bind scc_style_rom_bank_mapper_unit srbm_checker u_srbm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_read_data     (o_rsp.read_data),
    .i_rsp_data_source   (o_rsp.data_source),
    .i_rsp_flash_address (o_rsp.flash_address),
    .i_rsp_sound_address (o_rsp.sound_address),
    .i_rsp_sound_write   (o_rsp.sound_write)
);
